### design/hangul_jamo_syllable_composer_assert.svh
// Assertion macros used by the composer RTL.
// Depends on nothing; included by the modules that assert.
`ifndef HANGUL_JAMO_SYLLABLE_COMPOSER_ASSERT_SVH
`define HANGUL_JAMO_SYLLABLE_COMPOSER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define HJC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the following cycle.
`define HJC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

### design/hjc_pkg.sv
// Package for the Hangul jamo composer: beat types, classes and tables.
// Depends on nothing.
`default_nettype none
package hjc_pkg;
	localparam logic [20:0] SYL_BASE = 21'h00AC00;
	localparam logic [20:0] JAMO_FIRST = 21'h003131;
	localparam logic [20:0] VOWEL_FIRST = 21'h00314F;
	localparam logic [20:0] VOWEL_LAST = 21'h003163;
	localparam logic [4:0] NONE5 = 5'h1F;

	typedef struct packed {
		logic        mode;
		logic [20:0] code_point;
	} in_beat_t;

	typedef struct packed {
		logic        erase_prev;
		logic [1:0]  char_count;
		logic [20:0] first_char;
		logic [20:0] second_char;
	} out_beat_t;

	typedef enum logic [1:0] {
		CLS_CLEAR, CLS_CONS, CLS_VOWEL, CLS_OTHER
	} cls_t;

	// Classified beat handed from front to back.
	typedef struct packed {
		cls_t        cls;
		logic [4:0]  cho;   // initial index of a consonant
		logic [4:0]  jong;  // final index of a consonant, 0 if none
		logic [4:0]  vi;    // vowel index
		logic [20:0] cp;
	} cmd_t;

	function automatic logic [4:0] cons_cho(input logic [4:0] o);
		case (o)
			5'd0: return 5'd0;   5'd1: return 5'd1;   5'd3: return 5'd2;
			5'd6: return 5'd3;   5'd7: return 5'd4;   5'd8: return 5'd5;
			5'd16: return 5'd6;  5'd17: return 5'd7;  5'd18: return 5'd8;
			5'd20: return 5'd9;  5'd21: return 5'd10; 5'd22: return 5'd11;
			5'd23: return 5'd12; 5'd24: return 5'd13; 5'd25: return 5'd14;
			5'd26: return 5'd15; 5'd27: return 5'd16; 5'd28: return 5'd17;
			5'd29: return 5'd18;
			default: return NONE5;
		endcase
	endfunction

	function automatic logic [4:0] cons_jong(input logic [4:0] o);
		if (o <= 5'd6) return o + 5'd1;
		else if (o == 5'd7 || o == 5'd18 || o == 5'd24) return 5'd0;
		else if (o < 5'd18) return o;
		else if (o < 5'd24) return o - 5'd1;
		else return o - 5'd2;
	endfunction

	function automatic logic [4:0] jong_to_cho(input logic [4:0] j);
		case (j)
			5'd1: return 5'd0;   5'd2: return 5'd1;   5'd4: return 5'd2;
			5'd7: return 5'd3;   5'd8: return 5'd5;   5'd16: return 5'd6;
			5'd17: return 5'd7;  5'd19: return 5'd9;  5'd20: return 5'd10;
			5'd21: return 5'd11; 5'd22: return 5'd12; 5'd23: return 5'd14;
			5'd24: return 5'd15; 5'd25: return 5'd16; 5'd26: return 5'd17;
			5'd27: return 5'd18;
			default: return NONE5;
		endcase
	endfunction

	// Compound final from first final and second initial, 0 if none.
	function automatic logic [4:0] jong_comp(input logic [4:0] f, input logic [4:0] c);
		case ({f, c})
			{5'd1, 5'd9}: return 5'd3;   {5'd4, 5'd12}: return 5'd5;
			{5'd4, 5'd18}: return 5'd6;  {5'd8, 5'd0}: return 5'd9;
			{5'd8, 5'd6}: return 5'd10;  {5'd8, 5'd7}: return 5'd11;
			{5'd8, 5'd9}: return 5'd12;  {5'd8, 5'd16}: return 5'd13;
			{5'd8, 5'd17}: return 5'd14; {5'd8, 5'd18}: return 5'd15;
			{5'd17, 5'd9}: return 5'd18;
			default: return 5'd0;
		endcase
	endfunction

	// Split of a compound final: {kept final, moved initial}, NONE5 initial if simple.
	function automatic logic [9:0] jong_split(input logic [4:0] f);
		case (f)
			5'd3: return {5'd1, 5'd9};   5'd5: return {5'd4, 5'd12};
			5'd6: return {5'd4, 5'd18};  5'd9: return {5'd8, 5'd0};
			5'd10: return {5'd8, 5'd6};  5'd11: return {5'd8, 5'd7};
			5'd12: return {5'd8, 5'd9};  5'd13: return {5'd8, 5'd16};
			5'd14: return {5'd8, 5'd17}; 5'd15: return {5'd8, 5'd18};
			5'd18: return {5'd17, 5'd9};
			default: return {5'd0, NONE5};
		endcase
	endfunction

	// Compound vowel code (index+1) from first and second index, 0 if none.
	function automatic logic [4:0] vowel_comp(input logic [4:0] a, input logic [4:0] b);
		case ({a, b})
			{5'd8, 5'd0}: return 5'd10;   {5'd8, 5'd1}: return 5'd11;
			{5'd8, 5'd20}: return 5'd12;  {5'd13, 5'd4}: return 5'd15;
			{5'd13, 5'd5}: return 5'd16;  {5'd13, 5'd20}: return 5'd17;
			{5'd18, 5'd20}: return 5'd20;
			default: return 5'd0;
		endcase
	endfunction

	// Syllable code; cho*588 + jung*28 as shifts and adds.
	function automatic logic [20:0] syllable(input logic [4:0] cho, input logic [4:0] jung,
			input logic [4:0] jong);
		logic [20:0] c, j;
		c = {16'd0, cho};
		j = {16'd0, jung};
		return SYL_BASE + (c << 9) + (c << 6) + (c << 3) + (c << 2)
			+ (j << 4) + (j << 3) + (j << 2) + {16'd0, jong};
	endfunction
endpackage
`default_nettype wire

### design/hjc_front.sv
// Front end: accepts input beats and classifies each code point.
// Depends on hjc_pkg.
`default_nettype none
module hjc_front import hjc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_beat_t in_beat,
	input  wire logic     in_valid,
	output logic          in_ready,
	output cmd_t          cmd,
	output logic          cmd_valid,
	input  wire logic     cmd_ready
);
	logic [20:0] off;
	logic [4:0]  ch;
	cmd_t        cmd_d;

	always_comb begin
		off = in_beat.code_point - JAMO_FIRST;
		ch = cons_cho(off[4:0]);
		cmd_d.cp = in_beat.code_point;
		cmd_d.cho = ch;
		cmd_d.jong = cons_jong(off[4:0]);
		cmd_d.vi = in_beat.code_point[4:0] - VOWEL_FIRST[4:0];
		if (in_beat.mode)
			cmd_d.cls = CLS_CLEAR;
		else if (in_beat.code_point >= JAMO_FIRST && in_beat.code_point < VOWEL_FIRST
				&& ch != NONE5)
			cmd_d.cls = CLS_CONS;
		else if (in_beat.code_point >= VOWEL_FIRST && in_beat.code_point <= VOWEL_LAST)
			cmd_d.cls = CLS_VOWEL;
		else
			cmd_d.cls = CLS_OTHER;
	end

	// Two-entry queue toward the back end.
	cmd_t       q_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = q_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= cmd_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

### design/hjc_back.sv
// Back end: holds the composition state and produces result beats.
// Depends on hjc_pkg and the assertion macro header.
`default_nettype none
`include "hangul_jamo_syllable_composer_assert.svh"
module hjc_back import hjc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cmd_t  cmd,
	input  wire logic  cmd_valid,
	output logic       cmd_ready,
	output out_beat_t  out_beat,
	output logic       out_valid,
	input  wire logic  out_ready
);
	logic [4:0] ini_q, vow_q, fin_q;
	logic       comp_q;
	logic [4:0] ini_d, vow_d, fin_d, jc, vc, keep, nc;
	logic       comp_d;
	logic [9:0] sp;
	out_beat_t  r;
	logic       take;

	assign cmd_ready = !out_valid || out_ready;
	assign take = cmd_valid && cmd_ready;

	always_comb begin
		ini_d = ini_q; vow_d = vow_q; fin_d = fin_q; comp_d = comp_q;
		r.erase_prev = 1'b0;
		r.char_count = 2'd1;
		r.first_char = cmd.cp;
		r.second_char = 21'd0;
		jc = jong_comp(fin_q, cmd.cho);
		vc = vowel_comp(vow_q - 5'd1, cmd.vi);
		sp = jong_split(fin_q);
		keep = sp[9:5];
		nc = (sp[4:0] == NONE5) ? jong_to_cho(fin_q) : sp[4:0];
		if (nc == NONE5) nc = 5'd0;
		unique case (cmd.cls)
			CLS_CLEAR: begin
				ini_d = 5'd0; vow_d = 5'd0; fin_d = 5'd0; comp_d = 1'b0;
				r.char_count = 2'd0;
				r.first_char = 21'd0;
			end
			CLS_CONS: begin
				if (!comp_q || vow_q == 5'd0) begin
					ini_d = cmd.cho; vow_d = 5'd0; fin_d = 5'd0; comp_d = 1'b1;
				end else if (fin_q == 5'd0) begin
					if (cmd.jong != 5'd0) begin
						fin_d = cmd.jong;
						r.erase_prev = 1'b1;
						r.first_char = syllable(ini_q, vow_q - 5'd1, cmd.jong);
					end else comp_d = 1'b0;
				end else if (jc != 5'd0) begin
					fin_d = jc;
					r.erase_prev = 1'b1;
					r.first_char = syllable(ini_q, vow_q - 5'd1, jc);
				end else begin
					ini_d = cmd.cho; vow_d = 5'd0; fin_d = 5'd0;
				end
			end
			CLS_VOWEL: begin
				if (!comp_q) begin
					comp_d = 1'b0;
				end else if (vow_q == 5'd0) begin
					vow_d = cmd.vi + 5'd1;
					r.erase_prev = 1'b1;
					r.first_char = syllable(ini_q, cmd.vi, 5'd0);
				end else if (fin_q != 5'd0) begin
					r.erase_prev = 1'b1;
					r.char_count = 2'd2;
					r.first_char = syllable(ini_q, vow_q - 5'd1, keep);
					r.second_char = syllable(nc, cmd.vi, 5'd0);
					ini_d = nc; vow_d = cmd.vi + 5'd1; fin_d = 5'd0;
				end else if (vc != 5'd0) begin
					vow_d = vc;
					r.erase_prev = 1'b1;
					r.first_char = syllable(ini_q, vc - 5'd1, 5'd0);
				end else comp_d = 1'b0;
			end
			CLS_OTHER: comp_d = 1'b0;
			default: comp_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) out_beat <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ini_q <= 5'd0; vow_q <= 5'd0; fin_q <= 5'd0; comp_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				ini_q <= ini_d; vow_q <= vow_d; fin_q <= fin_d; comp_q <= comp_d;
			end
			if (take) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	`HJC_ASSERT_IMP(a_final_needs_vowel, clk, arst_n, fin_q != 5'd0, vow_q != 5'd0)
	`HJC_ASSERT_NEXT(a_clear_empties, clk, arst_n, take && cmd.cls == CLS_CLEAR,
		!comp_q && vow_q == 5'd0 && out_beat.char_count == 2'd0)
	`HJC_ASSERT_NEXT(a_hold_stalled, clk, arst_n, out_valid && !out_ready, $stable(out_beat))
endmodule
`default_nettype wire

### design/hangul_jamo_syllable_composer.sv
// Top level of the Hangul jamo syllable composer.
// Depends on hjc_pkg, hjc_front and hjc_back.
`default_nettype none
// Each input beat carries a mode bit and one typed Unicode code point; each
// accepted beat yields exactly one result beat with a delete-previous flag, a
// count of zero to two code points and the code points themselves. The block
// sustains one beat per clock while out_ready is held high: the front end
// classifies the code point and pushes it into a two-entry queue, and the back
// end takes it from the queue, updates the composition state and computes
// syllable codes combinationally into an output register. The composition state
// loop in the back end is what bounds the rate at one beat per cycle. Mode 1
// clears the composition and returns an empty result.
module hangul_jamo_syllable_composer import hjc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_beat_t in_beat,
	input  wire logic     in_valid,
	output logic          in_ready,
	output out_beat_t     out_beat,
	output logic          out_valid,
	input  wire logic     out_ready
);
	cmd_t cmd;
	logic cmd_valid, cmd_ready;

	hjc_front u_front (
		.clk, .arst_n, .in_beat, .in_valid, .in_ready,
		.cmd, .cmd_valid, .cmd_ready
	);

	hjc_back u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_ready,
		.out_beat, .out_valid, .out_ready
	);
endmodule
`default_nettype wire
